>>> src/sis_pkg.sv
// shared types and constants for the sorted integer set unit
// no dependencies; imported by sis_cell and sorted_integer_set_unit
package sis_pkg;

   // request kinds
   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_FIND   = 2'd2;
   localparam logic [1:0] ACT_GET    = 2'd3;

   // result status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_MISS    = 2'd1;
   localparam logic [1:0] STS_FULL    = 2'd2;
   localparam logic [1:0] STS_RANGE   = 2'd3;

   // width classes
   localparam logic [1:0] CLS_16 = 2'd0;
   localparam logic [1:0] CLS_32 = 2'd1;
   localparam logic [1:0] CLS_64 = 2'd2;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic cmp;   // compare cycle: cells latch their flags
      logic ins;   // update cycle: shift toward the tail and insert
      logic rem;   // update cycle: shift toward the head over the removed entry
   } cell_ctl_type;

   // narrowest class that holds a signed value
   function automatic logic [1:0] class_of(input logic [63:0] v);
      logic [1:0] c;
      if (&v[63:15] || ~|v[63:15]) begin
         c = CLS_16;
      end else if (&v[63:31] || ~|v[63:31]) begin
         c = CLS_32;
      end else begin
         c = CLS_64;
      end
      return c;
   endfunction

endpackage

>>> src/sorted_integer_set_unit.sv
// top level of the sorted integer set unit: sequencer, result register and cell row
// depends on sis_pkg and sis_cell
//
// The unit keeps up to CAPACITY distinct signed 64-bit values in ascending order, one
// value per cell in a row of cells. A request is taken when start is high and busy is
// low. Each request runs through a compare cycle and an update cycle: in the compare
// cycle each cell compares its entry with the key at once; in the update cycle the
// cells shift by one place toward the tail (add) or the head (remove), the position is
// encoded from where the "entry below key" flags end, and the result beat is registered.
// The result shows on the rsp_ ports with rsp_strobe for exactly one cycle; the receiver
// cannot stall it. busy is high only in the compare cycle, so a new request can be
// taken in the update cycle of the one before it. The row needs no clearing after
// reset, entries at and beyond the count are never reported. rsp_where and rsp_count
// carry the low seven bits of the position and count.
module sorted_integer_set_unit #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic signed [63:0] req_value,
   input  logic [5:0]         req_position,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_where,
   output logic signed [63:0] rsp_read_value,
   output logic [6:0]         rsp_count,
   output logic [1:0]         rsp_width_class
);
   import sis_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 7) ? CW : 7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_UPD
   } state_type;

   state_type state_ff, state_in;

   // request beat
   logic [1:0]         act_ff;
   logic signed [63:0] key_ff;
   logic [5:0]         pos_ff;

   // set state
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    class_ff, class_in;

   // result beat
   logic               strobe_ff;
   logic [1:0]         status_ff, status_in;
   logic [6:0]         where_ff, where_in;
   logic signed [63:0] read_ff, read_in;
   logic [6:0]         cnt_out_ff;

   // cell row
   cell_ctl_type       ctl;
   logic signed [63:0] cell_entry [CAPACITY];
   logic [CAPACITY-1:0] cell_lt, cell_eq, cell_boundary, cell_read;

   logic          accept;
   logic          hit;
   logic          full;
   logic          do_ins, do_rem;
   logic [CW-1:0] loc;
   logic [XW-1:0] loc_x, count_x;
   logic [1:0]    key_class;

   assign accept = start && !busy;
   assign busy   = (state_ff == ST_CMP);

   assign hit    = |cell_eq;
   assign full   = (count_ff == CW'(CAPACITY));
   assign do_ins = (act_ff == ACT_ADD) && !hit && !full;
   assign do_rem = (act_ff == ACT_REMOVE) && hit;
   assign key_class = class_of(key_ff);

   assign ctl.cmp = (state_ff == ST_CMP);
   assign ctl.ins = (state_ff == ST_UPD) && do_ins;
   assign ctl.rem = (state_ff == ST_UPD) && do_rem;

   // position encode from the one-hot boundary, tail case when every entry is below
   always_comb begin
      loc = cell_lt[CAPACITY-1] ? CW'(CAPACITY) : '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_boundary[i]) begin
            loc = loc | CW'(i);
         end
      end
   end

   // entry read for get, at most one cell selected
   always_comb begin
      read_in = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_read[i]) begin
            read_in = read_in | cell_entry[i];
         end
      end
   end

   assign loc_x = XW'(loc);

   always_comb begin
      status_in = STS_OK;
      where_in  = loc_x[6:0];
      count_in  = count_ff;
      class_in  = class_ff;
      unique case (act_ff)
         ACT_ADD: begin
            if (hit) begin
               status_in = STS_MISS;
            end else if (full) begin
               status_in = STS_FULL;
            end else begin
               count_in = count_ff + CW'(1);
               if (key_class > class_ff) begin
                  class_in = key_class;
               end
            end
         end
         ACT_REMOVE: begin
            if (!hit) begin
               status_in = STS_MISS;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         ACT_FIND: begin
            status_in = hit ? STS_OK : STS_MISS;
         end
         ACT_GET: begin
            where_in = {1'b0, pos_ff};
            if (cell_read == '0) begin
               status_in = STS_RANGE;
            end
         end
         default: begin
            status_in = STS_OK;
         end
      endcase
   end

   assign count_x = XW'(count_in);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            state_in = accept ? ST_CMP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         class_ff  <= CLS_16;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == ST_UPD);
         if (state_ff == ST_UPD) begin
            count_ff   <= count_in;
            class_ff   <= class_in;
            status_ff  <= status_in;
            where_ff   <= where_in;
            read_ff    <= (status_in == STS_OK && act_ff == ACT_GET) ? read_in : '0;
            cnt_out_ff <= count_x[6:0];
         end
      end
   end

   // request beat holds through the compare and update cycles
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         key_ff <= req_value;
         pos_ff <= req_position;
      end
   end

   // the row: each cell sees its neighbors' entries and flags
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [63:0] prev_entry, next_entry;
      logic               prev_lt;
      if (g == 0) begin : g_head
         assign prev_entry = cell_entry[0];
         assign prev_lt    = 1'b1;
      end else begin : g_body
         assign prev_entry = cell_entry[g-1];
         assign prev_lt    = cell_lt[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign next_entry = cell_entry[g];
      end else begin : g_mid
         assign next_entry = cell_entry[g+1];
      end
      sis_cell #(
         .INDEX (g),
         .CW    (CW)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .key        (key_ff),
         .position   (pos_ff),
         .prev_entry (prev_entry),
         .prev_lt    (prev_lt),
         .next_entry (next_entry),
         .entry      (cell_entry[g]),
         .lt         (cell_lt[g]),
         .eq         (cell_eq[g]),
         .boundary   (cell_boundary[g]),
         .read_sel   (cell_read[g])
      );
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_where       = where_ff;
   assign rsp_read_value  = read_ff;
   assign rsp_count       = cnt_out_ff;
   assign rsp_width_class = class_ff;

`ifndef SYNTHESIS
   // every accepted beat has its result beat taken after its compare and update cycles
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_strobe)
      else $error("result beat missing after accepted request");

   // a result only follows an update cycle
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_UPD))
      else $error("result strobe without update cycle");

   // count stays within the row
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   // width class never shrinks
   a_class_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> class_ff >= $past(class_ff))
      else $error("width class decreased");

   // a hit is never at more than one cell
   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> $onehot0(cell_eq))
      else $error("key matched more than one entry");
`endif

endmodule

>>> src/sis_cell.sv
// one cell of the sorted row: holds one entry and its compare flags
// depends on sis_pkg
module sis_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 7
) (
   input  logic                  clock,
   input  sis_pkg::cell_ctl_type ctl,
   input  logic [CW-1:0]         count,
   input  logic signed [63:0]    key,
   input  logic [5:0]            position,
   input  logic signed [63:0]    prev_entry,
   input  logic                  prev_lt,
   input  logic signed [63:0]    next_entry,
   output logic signed [63:0]    entry,
   output logic                  lt,
   output logic                  eq,
   output logic                  boundary,
   output logic                  read_sel
);
   import sis_pkg::*;

   localparam logic [CW-1:0] IDX = CW'(INDEX);
   localparam bit IN_RANGE = (INDEX < 64);

   logic signed [63:0] entry_ff, entry_in;
   logic               lt_ff, eq_ff;
   logic               valid;

   assign valid = IDX < count;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins && !lt_ff) begin
         entry_in = prev_lt ? key : prev_entry;
      end else if (ctl.rem && !lt_ff) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctl.cmp) begin
         lt_ff <= valid && (entry_ff < key);
         eq_ff <= valid && (entry_ff == key);
      end
   end

   assign entry    = entry_ff;
   assign lt       = lt_ff;
   assign eq       = eq_ff;
   // first cell whose entry is not below the key
   assign boundary = prev_lt && !lt_ff;
   assign read_sel = IN_RANGE && valid && (position == 6'(INDEX));

endmodule
